// ===== rtl/stuffed_frame_receiver_defines.svh =====
// ----------------------------------------------------------------------------
// Stuffed frame receiver assertion macros
// Concurrent check helpers; they compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef STUFFED_FRAME_RECEIVER_DEFINES_SVH
`define STUFFED_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTHESIS
// expr must never hold
`define SFR_ASSERT_NEVER(lbl, expr) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("sfr check failed: never");
// ante implies cons in the same cycle
`define SFR_ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("sfr check failed: implies");
// ante implies cons in the next cycle
`define SFR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("sfr check failed: next");
`else
`define SFR_ASSERT_NEVER(lbl, expr)
`define SFR_ASSERT_IMPLIES(lbl, ante, cons)
`define SFR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

// ===== rtl/sfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Stuffed frame receiver package
// Field widths, item kinds, framing constants and the result beat layout.
// ----------------------------------------------------------------------------
`default_nettype none

package sfr_pkg;

    // field widths
    localparam int KIND_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int INDEX_W    = 5;
    localparam int FILL_W     = 5;
    localparam int CMP_W      = BYTE_W + 1;   // holds length + 1 and any pointer
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_BYTE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_READ    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;

    // framing
    localparam logic [BYTE_W-1:0] FLAG_BYTE = 8'h7F;
    localparam logic [CMP_W-1:0]  MIN_FILL  = 9'd2;

    // result beat, lowest bit last
    typedef struct packed {
        logic                pad;
        logic                byte_dropped;
        logic [BYTE_W-1:0]   read_data;
        logic [FILL_W-1:0]   fill_position;
        logic                frame_ready;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/sfr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module sfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, holds while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/stuffed_frame_receiver.sv =====
// ----------------------------------------------------------------------------
// Stuffed frame receiver
// Byte-stuffed frame receiver with a length byte and a readable buffer.
// ----------------------------------------------------------------------------
// Pipeline: an input beat passes the decode stage, then the output register.
// Throughput: one beat per cycle while the result side is not stalled; the
//   buffer RAM port and the pointer/escape update loop set that figure.
// Reset: synchronous, active low; clears pointer, escape, frame flag, length
//   byte, buffer valid bits and the valid bits of both pipeline stages at once, no sweep.
`default_nettype none

`include "stuffed_frame_receiver_defines.svh"

module stuffed_frame_receiver #(
    parameter int BUFFER_DEPTH = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    // rx_byte[7:0], read_index[12:8], zero[15:13]
    input  wire logic [sfr_pkg::IN_DATA_W-1:0]  i_s_tdata,
    // kind[1:0]
    input  wire logic [sfr_pkg::KIND_W-1:0]     i_s_tuser,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    // frame_ready[0], fill_position[5:1], read_data[13:6], byte_dropped[14], zero[15]
    output logic      [sfr_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    import sfr_pkg::*;

    localparam int AW = $clog2(BUFFER_DEPTH);

    // state
    logic                r_esc;
    logic [AW-1:0]       r_ptr;
    logic                r_flag;
    logic [BYTE_W-1:0]   r_len;
    logic [BUFFER_DEPTH-1:0] r_valid;

    // pipeline
    logic                r_a_valid;
    logic                r_a_ready;
    logic [FILL_W-1:0]   r_a_fill;
    logic                r_a_rd_ok;
    logic                r_a_dropped;
    logic                r_o_valid;
    t_result             r_o_data;

    // next values
    logic                n_esc;
    logic [AW-1:0]       n_ptr;
    logic                n_flag;
    logic [BYTE_W-1:0]   n_len;

    logic [KIND_W-1:0]   kind;
    logic [BYTE_W-1:0]   rx_byte;
    logic [INDEX_W-1:0]  read_index;
    logic                acc;
    logic                take;
    logic                restart;
    logic                store;
    logic [AW-1:0]       wr_addr;
    logic [AW:0]         ptr_inc;
    logic [AW-1:0]       ptr_adv;
    logic [CMP_W-1:0]    n_ptr_ext;
    logic                hit;
    logic [CMP_W-1:0]    idx_ext;
    logic                rd_in;
    logic [AW-1:0]       rd_addr;
    logic                rd_ok;
    logic                is_read;
    logic                a_move;
    logic [BYTE_W-1:0]   ram_q;
    t_result             res;

    // field unpacking and handshake
    assign kind       = i_s_tuser;
    assign rx_byte    = i_s_tdata[BYTE_W-1:0];
    assign read_index = i_s_tdata[BYTE_W+INDEX_W-1:BYTE_W];
    assign a_move     = r_a_valid && (!r_o_valid || i_m_tready);
    assign o_s_tready = !r_a_valid || a_move;
    assign acc        = i_s_tvalid && o_s_tready;

    // byte decode: escape handling and write address
    assign take    = (kind == KIND_BYTE) && !r_flag;
    assign restart = r_esc && (rx_byte != FLAG_BYTE);
    assign store   = take && !(r_esc && (rx_byte == FLAG_BYTE));
    assign wr_addr = restart ? '0 : r_ptr;
    assign ptr_inc = {1'b0, wr_addr} + (AW+1)'(1);
    assign ptr_adv = (ptr_inc >= (AW+1)'(BUFFER_DEPTH)) ? '0 : ptr_inc[AW-1:0];

    // pointer, escape and length byte
    always_comb begin
        n_ptr = store ? ptr_adv : r_ptr;
        n_esc = take ? (!r_esc && (rx_byte == FLAG_BYTE)) : r_esc;
        n_len = (store && (wr_addr == '0)) ? rx_byte : r_len;
    end

    // completion check against the length byte
    assign n_ptr_ext = CMP_W'(n_ptr);
    assign hit = (n_ptr_ext > MIN_FILL) && (n_ptr_ext == ({1'b0, n_len} + CMP_W'(1)));

    // frame flag
    always_comb begin
        unique case (kind)
            KIND_BYTE:    n_flag = r_flag || hit;
            KIND_READ:    n_flag = r_flag;
            KIND_RELEASE: n_flag = 1'b0;
            KIND_UNUSED:  n_flag = r_flag;
            default:      n_flag = r_flag;
        endcase
    end

    // buffer read decode
    assign is_read = (kind == KIND_READ);
    assign idx_ext = CMP_W'(read_index);
    assign rd_in   = idx_ext < CMP_W'(BUFFER_DEPTH);
    assign rd_addr = idx_ext[AW-1:0];
    assign rd_ok   = is_read && rd_in && r_valid[rd_addr];

    sfr_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (acc && store),
        .i_waddr (wr_addr),
        .i_wdata (rx_byte),
        .i_re    (acc && is_read && rd_in),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // state update on accepted beats
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_esc   <= 1'b0;
            r_ptr   <= '0;
            r_flag  <= 1'b0;
            r_len   <= '0;
            r_valid <= '0;
        end else if (acc) begin
            r_esc  <= n_esc;
            r_ptr  <= n_ptr;
            r_flag <= n_flag;
            r_len  <= n_len;
            if (store) begin
                r_valid[wr_addr] <= 1'b1;
            end
        end
    end

    // decode stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_a_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a_ready   <= n_flag;
            r_a_fill    <= n_ptr_ext[FILL_W-1:0];
            r_a_rd_ok   <= rd_ok;
            r_a_dropped <= (kind == KIND_BYTE) && r_flag;
        end
    end

    // result beat assembly
    always_comb begin
        res               = '0;
        res.frame_ready   = r_a_ready;
        res.fill_position = r_a_fill;
        res.read_data     = r_a_rd_ok ? ram_q : '0;
        res.byte_dropped  = r_a_dropped;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (!r_o_valid || i_m_tready) begin
            r_o_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_move) begin
            r_o_data <= res;
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;

    // checks
    `SFR_ASSERT_NEXT(release_clears_flag, acc && (kind == KIND_RELEASE), !r_flag)
    `SFR_ASSERT_IMPLIES(flag_needs_fill, r_flag, CMP_W'(r_ptr) > MIN_FILL)
    `SFR_ASSERT_NEXT(dropped_keeps_ptr, acc && (kind == KIND_BYTE) && r_flag, $stable(r_ptr))

endmodule

`default_nettype wire
